// ----- design/dctg_pkg.sv -----
package dctg_pkg;

  localparam int unsigned FreqW   = 16;
  localparam int unsigned DurW    = 16;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned DutyCW  = 7;
  localparam int unsigned TickW   = 20;
  localparam int unsigned PeriodW = 23;
  localparam int unsigned DivW    = 27;
  localparam int unsigned DivCntW = 5;
  localparam int unsigned PcW     = 4;
  localparam int unsigned RecipW  = 28;
  localparam int unsigned RecipSh = 34;

  localparam logic [TickW-1:0]   UsPerSec = 20'd1000000;
  localparam logic [9:0]         UsPerMs  = 10'd1000;
  localparam logic [DutyCW-1:0]  DutyMax  = 7'd100;
  localparam logic [TickW-1:0]   PctDiv   = 20'd100;
  localparam logic [DivCntW-1:0] DivSteps = 5'(DivW);
  // ceil(2^34 / 100), exact for dividends below 2^30
  localparam logic [RecipW-1:0]  PctRecip = 28'd171798692;

  typedef enum logic [3:0] {
    OpNop,
    OpLoad,
    OpDivPeriod,
    OpDivStep,
    OpSavePeriod,
    OpDivHigh,
    OpMulHigh,
    OpSaveHigh,
    OpDivCount,
    OpStart,
    OpTick,
    OpEmit
  } op_e;

  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondNoAccept,
    CondTick,
    CondReject,
    CondDivRun,
    CondOutBusy
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uword_t;

  localparam logic [PcW-1:0] PcWait    = 4'd0;
  localparam logic [PcW-1:0] PcDecode  = 4'd1;
  localparam logic [PcW-1:0] PcCheck   = 4'd2;
  localparam logic [PcW-1:0] PcPerLd   = 4'd3;
  localparam logic [PcW-1:0] PcPerDiv  = 4'd4;
  localparam logic [PcW-1:0] PcPerSave = 4'd5;
  localparam logic [PcW-1:0] PcHiLd    = 4'd6;
  localparam logic [PcW-1:0] PcHiDiv   = 4'd7;
  localparam logic [PcW-1:0] PcHiSave  = 4'd8;
  localparam logic [PcW-1:0] PcCntLd   = 4'd9;
  localparam logic [PcW-1:0] PcCntDiv  = 4'd10;
  localparam logic [PcW-1:0] PcStart   = 4'd11;
  localparam logic [PcW-1:0] PcTick    = 4'd12;
  localparam logic [PcW-1:0] PcEmit    = 4'd13;
  localparam logic [PcW-1:0] PcReturn  = 4'd14;

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      PcWait:    w = '{OpLoad,       CondNoAccept, PcWait};
      PcDecode:  w = '{OpNop,        CondTick,     PcTick};
      PcCheck:   w = '{OpNop,        CondReject,   PcEmit};
      PcPerLd:   w = '{OpDivPeriod,  CondNever,    PcWait};
      PcPerDiv:  w = '{OpDivStep,    CondDivRun,   PcPerDiv};
      PcPerSave: w = '{OpSavePeriod, CondNever,    PcWait};
      PcHiLd:    w = '{OpDivHigh,    CondNever,    PcWait};
      PcHiDiv:   w = '{OpMulHigh,    CondNever,    PcWait};
      PcHiSave:  w = '{OpSaveHigh,   CondNever,    PcWait};
      PcCntLd:   w = '{OpDivCount,   CondNever,    PcWait};
      PcCntDiv:  w = '{OpDivStep,    CondDivRun,   PcCntDiv};
      PcStart:   w = '{OpStart,      CondAlways,   PcEmit};
      PcTick:    w = '{OpTick,       CondNever,    PcWait};
      PcEmit:    w = '{OpEmit,       CondOutBusy,  PcEmit};
      PcReturn:  w = '{OpNop,        CondAlways,   PcWait};
      default:   w = '{OpNop,        CondAlways,   PcWait};
    endcase
    return w;
  endfunction

endpackage

// ----- design/duty_cycle_tone_generator_unit.sv -----
// Square-wave tone generator with duty control. A command word (tuser = 0)
// carries frequency in Hz, duration in ms and duty in percent; a tick word
// (tuser = 1) advances the waveform by one microsecond. Every input word
// yields exactly one output word with the pin level, the busy flag and
// whether a command was taken. A command is rejected while a tone plays or
// when its frequency is zero. Control is a microcode table stepping a small
// datapath around one shared restoring divider that retires one quotient bit
// per cycle over 27 bits; the percent scaling of the high time is a
// reciprocal multiply. An accepted command runs two such divisions before
// its output word. After a result has been handed to the output register,
// control steps through a return state back to the wait state, where a new
// word is taken; the output register holds one result while the next word
// is in progress, and control waits in its emit state while the output
// register is full and not being drained.
module duty_cycle_tone_generator_unit
  import dctg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // frequency_hz, duration_ms, duty_percent
  input  logic        s_axis_tuser_i,   // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // pin_level, busy_res, command_taken, zero pad
);

  logic [PcW-1:0]     pc_q, pc_d;
  uword_t             uw;
  logic               cond_hit;
  logic               in_acc;

  logic               mode_q;
  logic [FreqW-1:0]   freq_q;
  logic [DurW-1:0]    dur_q;
  logic [DutyCW-1:0]  duty_q;
  logic [DutyW-1:0]   duty_in;

  logic [DivW-1:0]    quo_q, quo_d;
  logic [TickW-1:0]   rem_q, rem_d;
  logic [TickW-1:0]   den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [TickW:0]     rem_sh;
  logic               rem_ge;

  logic [TickW-1:0]   per_q, per_d;
  logic [TickW-1:0]   high_q, high_d;
  logic [TickW-1:0]   low_q, low_d;
  logic [TickW-1:0]   phase_q, phase_d;
  logic [PeriodW-1:0] periods_q, periods_d;
  logic               active_q, active_d;
  logic               in_high_q, in_high_d;
  logic               taken_q, taken_d;

  logic [TickW-1:0]   phase_dec;
  logic [PeriodW-1:0] periods_dec;
  logic [DivW-1:0]    prod_high;
  logic [DivW-1:0]    prod_dur;
  logic [DivW+RecipW-1:0] prod_recip;

  logic               out_valid_q, out_valid_d;
  logic [2:0]         out_data_q, out_data_d;
  logic               out_busy;

  assign uw              = ucode(pc_q);
  assign s_axis_tready_o = (pc_q == PcWait);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_busy        = out_valid_q & ~m_axis_tready_i;
  assign duty_in         = s_axis_tdata_i[39:32];

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_data_q};

  // shared restoring divider step
  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  assign prod_high   = DivW'(per_q) * DivW'(duty_q);
  assign prod_dur    = DivW'(dur_q) * DivW'(UsPerMs);
  assign prod_recip  = (DivW+RecipW)'(quo_q) * (DivW+RecipW)'(PctRecip);
  assign phase_dec   = (phase_q != '0) ? phase_q - 1'b1 : phase_q;
  assign periods_dec = periods_q - 1'b1;

  always_comb begin
    unique case (uw.cond)
      CondNever:    cond_hit = 1'b0;
      CondAlways:   cond_hit = 1'b1;
      CondNoAccept: cond_hit = ~in_acc;
      CondTick:     cond_hit = mode_q;
      CondReject:   cond_hit = active_q | (freq_q == '0);
      CondDivRun:   cond_hit = (cnt_q != DivCntW'(1));
      CondOutBusy:  cond_hit = out_busy;
      default:      cond_hit = 1'b1;
    endcase
    pc_d = cond_hit ? uw.target : pc_q + 1'b1;
  end

  always_comb begin
    quo_d       = quo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    per_d       = per_q;
    high_d      = high_q;
    low_d       = low_q;
    phase_d     = phase_q;
    periods_d   = periods_q;
    active_d    = active_q;
    in_high_d   = in_high_q;
    taken_d     = taken_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_data_d  = out_data_q;

    unique case (uw.op)
      OpNop: begin
      end
      OpLoad: begin
        taken_d = 1'b0;
      end
      OpDivPeriod: begin
        quo_d = DivW'(UsPerSec);
        rem_d = '0;
        den_d = TickW'(freq_q);
        cnt_d = DivSteps;
      end
      OpDivStep: begin
        quo_d = {quo_q[DivW-2:0], rem_ge};
        rem_d = rem_ge ? TickW'(rem_sh - {1'b0, den_q}) : TickW'(rem_sh);
        cnt_d = cnt_q - 1'b1;
      end
      OpSavePeriod: begin
        per_d = quo_q[TickW-1:0];
      end
      OpDivHigh: begin
        quo_d = prod_high;
      end
      OpMulHigh: begin
        quo_d = DivW'(prod_recip[DivW+RecipW-1:RecipSh]);
      end
      OpSaveHigh: begin
        high_d = quo_q[TickW-1:0];
        low_d  = per_q - quo_q[TickW-1:0];
      end
      OpDivCount: begin
        quo_d = prod_dur;
        rem_d = '0;
        den_d = per_q;
        cnt_d = DivSteps;
      end
      OpStart: begin
        taken_d   = 1'b1;
        periods_d = quo_q[PeriodW-1:0];
        if (quo_q[PeriodW-1:0] == '0) begin
          active_d  = 1'b0;
          in_high_d = 1'b0;
          phase_d   = '0;
        end else begin
          active_d  = 1'b1;
          in_high_d = (high_q != '0);
          phase_d   = (high_q != '0) ? high_q : low_q;
        end
      end
      OpTick: begin
        if (active_q) begin
          if (phase_dec != '0) begin
            phase_d = phase_dec;
          end else if (in_high_q && (low_q != '0)) begin
            in_high_d = 1'b0;
            phase_d   = low_q;
          end else if (periods_dec == '0) begin
            active_d  = 1'b0;
            in_high_d = 1'b0;
            phase_d   = '0;
            periods_d = '0;
          end else begin
            periods_d = periods_dec;
            in_high_d = (high_q != '0);
            phase_d   = (high_q != '0) ? high_q : low_q;
          end
        end
      end
      OpEmit: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_data_d  = {taken_q, active_q, active_q & in_high_q};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcWait;
      active_q    <= 1'b0;
      in_high_q   <= 1'b0;
      high_q      <= '0;
      low_q       <= '0;
      phase_q     <= '0;
      periods_q   <= '0;
      taken_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      active_q    <= active_d;
      in_high_q   <= in_high_d;
      high_q      <= high_d;
      low_q       <= low_d;
      phase_q     <= phase_d;
      periods_q   <= periods_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= s_axis_tuser_i;
      freq_q <= s_axis_tdata_i[15:0];
      dur_q  <= s_axis_tdata_i[31:16];
      duty_q <= (duty_in > DutyW'(DutyMax)) ? DutyMax : duty_in[DutyCW-1:0];
    end
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    cnt_q      <= cnt_d;
    per_q      <= per_d;
    out_data_q <= out_data_d;
  end

endmodule
